>>> rtl/cvpi_pkg.sv
// Shared constants, types and the CORDIC angle table of the cone volume point test.
package cvpi_pkg;

   // default geometry of the coordinate words
   localparam int CVPI_COORD_BITS = 32;
   localparam int CVPI_FRAC_BITS  = 16;

   // CORDIC datapath: vector normalized to bit 59, angle in Q6.30
   localparam int CORD_W     = 64;
   localparam int NORM_W     = 60;
   localparam int NORM_STEPS = 6;
   localparam int ANG_W      = 36;
   localparam int ANG_FRAC   = 30;
   localparam int CORDIC_N   = 31;

   typedef logic signed [CORD_W-1:0] cord_type;
   typedef logic        [NORM_W-1:0] norm_type;
   typedef logic signed [ANG_W-1:0]  ang_type;

   // pi in Q6.30, rounded
   localparam ang_type PI_Q30 = 36'sd3373259426;

   // register index codes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_LENGTH_Z = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHI_LOW       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PHI_HIGH      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_CIRCLE   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_TAN     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_LEVEL   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_TAN     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_LEVEL   = 4'd7;

   // register reset values
   localparam int HALF_LENGTH_Z_RST = 65536;
   localparam int PHI_LOW_RST       = -205887;
   localparam int PHI_HIGH_RST      = 205887;
   localparam int INNER_LEVEL_RST   = 0;
   localparam int OUTER_LEVEL_RST   = 65536;

   // atan(2^-idx) in Q6.30, rounded; beyond idx 10 it equals 2^-idx
   function automatic ang_type cvpi_atan(input int idx);
      ang_type v;
      case (idx)
         0:  v = 36'sd843314857;
         1:  v = 36'sd497837829;
         2:  v = 36'sd263043837;
         3:  v = 36'sd133525159;
         4:  v = 36'sd67021687;
         5:  v = 36'sd33543516;
         6:  v = 36'sd16775851;
         7:  v = 36'sd8388437;
         8:  v = 36'sd4194283;
         9:  v = 36'sd2097149;
         10: v = 36'sd1048576;
         default: v = ang_type'(ANG_W'(1) << (ANG_FRAC - idx));
      endcase
      return v;
   endfunction

endpackage

>>> rtl/cvpi_sqrt_cell.sv
// One bit of the restoring integer square root, registered.
module cvpi_sqrt_cell #(
   parameter int W      = 32,
   parameter int BIT    = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_valid,
   input  logic [2*W-1:0]    up_rem,
   input  logic [W-1:0]      up_root,
   input  logic [SIDE_W-1:0] up_side,
   output logic              dn_valid,
   output logic [2*W-1:0]    dn_rem,
   output logic [W-1:0]      dn_root,
   output logic [SIDE_W-1:0] dn_side
);
   logic              valid_ff;
   logic [2*W-1:0]    rem_ff, rem_in;
   logic [W-1:0]      root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;
   logic [2*W:0]      trial;
   logic              take;

   // try setting this root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
   assign trial   = ((2*W+1)'(up_root) << (BIT + 1)) + ((2*W+1)'(1) << (2 * BIT));
   assign take    = (2*W+1)'(up_rem) >= trial;
   assign rem_in  = take ? (up_rem - trial[2*W-1:0]) : up_rem;
   assign root_in = take ? (up_root | (W'(1) << BIT)) : up_root;

   // advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_side  = side_ff;
endmodule

>>> rtl/cvpi_div_cell.sv
// One quotient bit of the restoring division tol * 2^F / r, registered.
module cvpi_div_cell #(
   parameter int W      = 32,
   parameter int FB     = 16,
   parameter int BIT    = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_valid,
   input  logic [W-1:0]      up_div,
   input  logic [W-2:0]      up_tol,
   input  logic [W-1:0]      up_rem,
   input  logic [FB+3:0]     up_quo,
   input  logic [SIDE_W-1:0] up_side,
   output logic              dn_valid,
   output logic [W-1:0]      dn_div,
   output logic [W-2:0]      dn_tol,
   output logic [W-1:0]      dn_rem,
   output logic [FB+3:0]     dn_quo,
   output logic [SIDE_W-1:0] dn_side
);
   localparam int QW = FB + 4;

   logic              valid_ff;
   logic [W-1:0]      div_ff;
   logic [W-2:0]      tol_ff;
   logic [W-1:0]      rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [SIDE_W-1:0] side_ff;
   logic              dbit;
   logic [W:0]        part;
   logic [W:0]        diff;
   logic              take;

   // next dividend bit: tolerance bits above the fraction, zeros below
   generate
      if (BIT >= FB) begin : g_tol_bit
         assign dbit = up_tol[BIT-FB];
      end else begin : g_zero_bit
         assign dbit = 1'b0;
      end
   endgenerate

   // shift in, compare and subtract
   assign part   = {up_rem, dbit};
   assign diff   = part - {1'b0, up_div};
   assign take   = part >= {1'b0, up_div};
   assign rem_in = take ? diff[W-1:0] : part[W-1:0];
   assign quo_in = take ? (up_quo | (QW'(1) << BIT)) : up_quo;

   // advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= up_div;
         tol_ff  <= up_tol;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_div   = div_ff;
   assign dn_tol   = tol_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;
   assign dn_side  = side_ff;
endmodule

>>> rtl/cvpi_norm_cell.sv
// One step of the normalizing shifter that brings the larger vector leg up to bit 59.
module cvpi_norm_cell #(
   parameter int SHIFT  = 1,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               up_valid,
   input  cvpi_pkg::norm_type up_ax,
   input  cvpi_pkg::norm_type up_ay,
   input  cvpi_pkg::norm_type up_mag,
   input  logic [SIDE_W-1:0]  up_side,
   output logic               dn_valid,
   output cvpi_pkg::norm_type dn_ax,
   output cvpi_pkg::norm_type dn_ay,
   output cvpi_pkg::norm_type dn_mag,
   output logic [SIDE_W-1:0]  dn_side
);
   import cvpi_pkg::*;

   logic              valid_ff;
   norm_type          ax_ff, ax_in;
   norm_type          ay_ff, ay_in;
   norm_type          mag_ff, mag_in;
   logic [SIDE_W-1:0] side_ff;
   logic              go;

   // shift when the magnitude stays below 2^NORM_W afterwards
   assign go     = up_mag[NORM_W-1 -: SHIFT] == '0;
   assign ax_in  = go ? (up_ax << SHIFT) : up_ax;
   assign ay_in  = go ? (up_ay << SHIFT) : up_ay;
   assign mag_in = go ? (up_mag << SHIFT) : up_mag;

   // advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         mag_ff  <= mag_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_ax    = ax_ff;
   assign dn_ay    = ay_ff;
   assign dn_mag   = mag_ff;
   assign dn_side  = side_ff;
endmodule

>>> rtl/cvpi_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
module cvpi_cordic_cell #(
   parameter int IDX    = 0,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               up_valid,
   input  cvpi_pkg::cord_type up_cx,
   input  cvpi_pkg::cord_type up_cy,
   input  cvpi_pkg::ang_type  up_ang,
   input  logic [SIDE_W-1:0]  up_side,
   output logic               dn_valid,
   output cvpi_pkg::cord_type dn_cx,
   output cvpi_pkg::cord_type dn_cy,
   output cvpi_pkg::ang_type  dn_ang,
   output logic [SIDE_W-1:0]  dn_side
);
   import cvpi_pkg::*;

   localparam ang_type STEP = cvpi_atan(IDX);

   logic              valid_ff;
   cord_type          cx_ff, cx_in;
   cord_type          cy_ff, cy_in;
   ang_type           ang_ff, ang_in;
   logic [SIDE_W-1:0] side_ff;
   cord_type          dx;
   cord_type          dy;
   logic              pos;

   // rotate toward the x axis
   assign dx     = up_cy >>> IDX;
   assign dy     = up_cx >>> IDX;
   assign pos    = !up_cy[CORD_W-1];
   assign cx_in  = pos ? (up_cx + dx) : (up_cx - dx);
   assign cy_in  = pos ? (up_cy - dy) : (up_cy + dy);
   assign ang_in = pos ? (up_ang + STEP) : (up_ang - STEP);

   // advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         ang_ff  <= ang_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_cx    = cx_ff;
   assign dn_cy    = cy_ff;
   assign dn_ang   = ang_ff;
   assign dn_side  = side_ff;
endmodule

>>> rtl/cone_volume_point_inside.sv
// Top level of the cone volume point test: registers, cell chains and final checks.
//
// Usage: a point (req_pos_x/y/z, req_tolerance) is taken on the req_ channel at each
// edge where req_valid is high and req_stall is low; one rsp_is_inside bit comes back
// on the rsp_ channel for every point, in order. The geometry lives in eight registers
// written through the csr_ channel (csr_index, csr_wdata); csr_ready is always high and
// indexes beyond the list are ignored. Write them only while no point is in flight.
// Throughput is one point per cycle while rsp_stall does not hold the chain: every stage
// hands its data to the next one whenever the chain advances. A point passes through the
// square-root chain (one cell per root bit), the phi-tolerance divider chain
// (FRAC_BITS + 4 cells), a six-step normalizer and the 31-cell CORDIC chain for atan2.
// Reset clears all valid flags and loads the register reset values.
// While the receiver holds rsp_stall with a result pending, the whole chain holds and
// req_stall is raised; no transaction is lost or repeated.
module cone_volume_point_inside #(
   parameter int COORD_BITS = cvpi_pkg::CVPI_COORD_BITS,
   parameter int FRAC_BITS  = cvpi_pkg::CVPI_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_pos_x,
   input  logic signed [COORD_BITS-1:0]          req_pos_y,
   input  logic signed [COORD_BITS-1:0]          req_pos_z,
   input  logic        [COORD_BITS-2:0]          req_tolerance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_is_inside,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [cvpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [COORD_BITS-1:0]          csr_wdata
);
   import cvpi_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int FB    = FRAC_BITS;
   localparam int TOL_W = CB - 1;
   localparam int PHI_W = FB + 4;
   localparam int TAN_W = FB + 8;
   localparam int SQ_W  = 2 * CB;
   localparam int DQ_W  = FB + 4;
   localparam int PT_W  = FB + 5;
   localparam int PC_W  = FB + 7;
   localparam int DW    = CB + 1;
   localparam int PW    = DW + TAN_W;
   // side data carried through each chain
   localparam int SA = CB + TOL_W + 3 + 2 * CB;
   localparam int SB = CB + 3 + 2 * CB + 1;
   localparam int SC = CB + TOL_W + 3 + CB + DQ_W + 1;
   localparam int SD = CB + TOL_W + 1 + CB + DQ_W + 1;

   // ---------------- configuration registers ----------------
   logic        [TOL_W-1:0] half_length_z_ff;
   logic signed [PHI_W-1:0] phi_low_ff;
   logic signed [PHI_W-1:0] phi_high_ff;
   logic                    full_circle_ff;
   logic        [TAN_W-1:0] inner_tan_ff;
   logic signed [CB-1:0]    inner_level_ff;
   logic        [TAN_W-1:0] outer_tan_ff;
   logic signed [CB-1:0]    outer_level_ff;

   assign csr_ready = 1'b1;

   // decode register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         half_length_z_ff <= TOL_W'(HALF_LENGTH_Z_RST);
         phi_low_ff       <= PHI_W'(PHI_LOW_RST);
         phi_high_ff      <= PHI_W'(PHI_HIGH_RST);
         full_circle_ff   <= 1'b1;
         inner_tan_ff     <= '0;
         inner_level_ff   <= CB'(INNER_LEVEL_RST);
         outer_tan_ff     <= '0;
         outer_level_ff   <= CB'(OUTER_LEVEL_RST);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HALF_LENGTH_Z: half_length_z_ff <= csr_wdata[TOL_W-1:0];
            REG_PHI_LOW:       phi_low_ff       <= csr_wdata[PHI_W-1:0];
            REG_PHI_HIGH:      phi_high_ff      <= csr_wdata[PHI_W-1:0];
            REG_FULL_CIRCLE:   full_circle_ff   <= csr_wdata[0];
            REG_INNER_TAN:     inner_tan_ff     <= csr_wdata[TAN_W-1:0];
            REG_INNER_LEVEL:   inner_level_ff   <= csr_wdata;
            REG_OUTER_TAN:     outer_tan_ff     <= csr_wdata[TAN_W-1:0];
            REG_OUTER_LEVEL:   outer_level_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic en;
   logic rsp_valid_ff;

   // hold the whole chain while a result waits on a stalled receiver
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------- stage 0: input transaction ----------------
   logic                     v0_ff;
   logic signed [CB-1:0]     x0_ff, y0_ff, z0_ff;
   logic        [TOL_W-1:0]  tol0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff   <= req_pos_x;
         y0_ff   <= req_pos_y;
         z0_ff   <= req_pos_z;
         tol0_ff <= req_tolerance;
      end
   end

   // ---------------- stage 1: magnitudes and z slab ----------------
   logic              v1_ff;
   logic [SA-1:0]     sa1_ff, sa1_in;
   logic [CB-1:0]     ux1_in, uy1_in;
   logic signed [CB:0] z_e, tol_e, hz_e;
   logic              zfail1_in;

   assign ux1_in    = x0_ff[CB-1] ? CB'(-x0_ff) : CB'(x0_ff);
   assign uy1_in    = y0_ff[CB-1] ? CB'(-y0_ff) : CB'(y0_ff);
   assign z_e       = {z0_ff[CB-1], z0_ff};
   assign tol_e     = {2'b00, tol0_ff};
   assign hz_e      = {2'b00, half_length_z_ff};
   assign zfail1_in = ((z_e + tol_e) < -hz_e) || ((z_e - tol_e) > hz_e);
   assign sa1_in    = {z0_ff, tol0_ff, zfail1_in, x0_ff[CB-1], y0_ff[CB-1],
                       ux1_in, uy1_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa1_ff <= sa1_in;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic            v2_ff;
   logic [SA-1:0]   sa2_ff;
   logic [SQ_W-1:0] sqx2_ff, sqy2_ff;
   logic [CB-1:0]   ux1, uy1;

   assign ux1 = sa1_ff[2*CB-1:CB];
   assign uy1 = sa1_ff[CB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa2_ff  <= sa1_ff;
         sqx2_ff <= SQ_W'(ux1) * SQ_W'(ux1);
         sqy2_ff <= SQ_W'(uy1) * SQ_W'(uy1);
      end
   end

   // ---------------- stage 3: sum of squares ----------------
   logic            v3_ff;
   logic [SA-1:0]   sa3_ff;
   logic [SQ_W-1:0] s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa3_ff <= sa2_ff;
         s3_ff  <= sqx2_ff + sqy2_ff;
      end
   end

   // ---------------- square root chain ----------------
   logic            sv    [CB+1];
   logic [SQ_W-1:0] srem  [CB+1];
   logic [CB-1:0]   sroot [CB+1];
   logic [SA-1:0]   sside [CB+1];

   assign sv[0]    = v3_ff;
   assign srem[0]  = s3_ff;
   assign sroot[0] = '0;
   assign sside[0] = sa3_ff;

   generate
      for (genvar k = 0; k < CB; k++) begin : g_sqrt
         cvpi_sqrt_cell #(
            .W      (CB),
            .BIT    (CB - 1 - k),
            .SIDE_W (SA)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .up_valid (sv[k]),
            .up_rem   (srem[k]),
            .up_root  (sroot[k]),
            .up_side  (sside[k]),
            .dn_valid (sv[k+1]),
            .dn_rem   (srem[k+1]),
            .dn_root  (sroot[k+1]),
            .dn_side  (sside[k+1])
         );
      end
   endgenerate

   // unpack after the root
   logic signed [CB-1:0]    a_z;
   logic        [TOL_W-1:0] a_tol;
   logic                    a_zfail, a_xneg, a_yneg;
   logic        [CB-1:0]    a_ux, a_uy;
   logic                    a_sat;

   assign {a_z, a_tol, a_zfail, a_xneg, a_yneg, a_ux, a_uy} = sside[CB];
   // phi tolerance saturates when tol >= 16 * r
   assign a_sat = (CB+4)'(a_tol) >= {sroot[CB], 4'b0000};

   // ---------------- phi tolerance divider chain ----------------
   logic             dv    [DQ_W+1];
   logic [CB-1:0]    ddiv  [DQ_W+1];
   logic [TOL_W-1:0] dtol  [DQ_W+1];
   logic [CB-1:0]    drem  [DQ_W+1];
   logic [DQ_W-1:0]  dquo  [DQ_W+1];
   logic [SB-1:0]    dside [DQ_W+1];

   assign dv[0]    = sv[CB];
   assign ddiv[0]  = sroot[CB];
   assign dtol[0]  = a_tol;
   assign drem[0]  = CB'(a_tol >> 4);
   assign dquo[0]  = '0;
   assign dside[0] = {a_z, a_zfail, a_xneg, a_yneg, a_ux, a_uy, a_sat};

   generate
      for (genvar k = 0; k < DQ_W; k++) begin : g_div
         cvpi_div_cell #(
            .W      (CB),
            .FB     (FB),
            .BIT    (DQ_W - 1 - k),
            .SIDE_W (SB)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .up_valid (dv[k]),
            .up_div   (ddiv[k]),
            .up_tol   (dtol[k]),
            .up_rem   (drem[k]),
            .up_quo   (dquo[k]),
            .up_side  (dside[k]),
            .dn_valid (dv[k+1]),
            .dn_div   (ddiv[k+1]),
            .dn_tol   (dtol[k+1]),
            .dn_rem   (drem[k+1]),
            .dn_quo   (dquo[k+1]),
            .dn_side  (dside[k+1])
         );
      end
   endgenerate

   // unpack after the divider
   logic signed [CB-1:0] b_z;
   logic                 b_zfail, b_xneg, b_yneg, b_sat;
   logic        [CB-1:0] b_ux, b_uy;

   assign {b_z, b_zfail, b_xneg, b_yneg, b_ux, b_uy, b_sat} = dside[DQ_W];

   // ---------------- normalizer chain ----------------
   logic          nv    [NORM_STEPS+1];
   norm_type      nax   [NORM_STEPS+1];
   norm_type      nay   [NORM_STEPS+1];
   norm_type      nmag  [NORM_STEPS+1];
   logic [SC-1:0] nside [NORM_STEPS+1];

   assign nv[0]    = dv[DQ_W];
   assign nax[0]   = NORM_W'(b_ux);
   assign nay[0]   = NORM_W'(b_uy);
   assign nmag[0]  = (b_ux > b_uy) ? NORM_W'(b_ux) : NORM_W'(b_uy);
   assign nside[0] = {b_z, dtol[DQ_W], b_zfail, b_xneg, b_yneg, ddiv[DQ_W],
                      dquo[DQ_W], b_sat};

   generate
      for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
         cvpi_norm_cell #(
            .SHIFT  (1 << (NORM_STEPS - 1 - k)),
            .SIDE_W (SC)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .up_valid (nv[k]),
            .up_ax    (nax[k]),
            .up_ay    (nay[k]),
            .up_mag   (nmag[k]),
            .up_side  (nside[k]),
            .dn_valid (nv[k+1]),
            .dn_ax    (nax[k+1]),
            .dn_ay    (nay[k+1]),
            .dn_mag   (nmag[k+1]),
            .dn_side  (nside[k+1])
         );
      end
   endgenerate

   // ---------------- fold into the right half plane ----------------
   logic signed [CB-1:0]    c_z;
   logic        [TOL_W-1:0] c_tol;
   logic                    c_zfail, c_xneg, c_yneg, c_sat;
   logic        [CB-1:0]    c_r;
   logic        [DQ_W-1:0]  c_quo;
   cord_type                ay_s;
   logic                    fv_ff;
   cord_type                fcx_ff, fcy_ff;
   ang_type                 fang_ff;
   logic [SD-1:0]           fside_ff;

   assign {c_z, c_tol, c_zfail, c_xneg, c_yneg, c_r, c_quo, c_sat} = nside[NORM_STEPS];
   assign ay_s = cord_type'(CORD_W'(nay[NORM_STEPS]));

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (en) begin
         fv_ff <= nv[NORM_STEPS];
      end
   end

   // negative x: rotate by pi (+pi on y >= 0) before the micro-rotations
   always_ff @(posedge clock) begin
      if (en) begin
         fcx_ff   <= cord_type'(CORD_W'(nax[NORM_STEPS]));
         fcy_ff   <= (c_xneg ^ c_yneg) ? -ay_s : ay_s;
         fang_ff  <= !c_xneg ? ang_type'(0) : (c_yneg ? -PI_Q30 : PI_Q30);
         fside_ff <= {c_z, c_tol, c_zfail, c_r, c_quo, c_sat};
      end
   end

   // ---------------- CORDIC chain ----------------
   logic          cv    [CORDIC_N+1];
   cord_type      ccx   [CORDIC_N+1];
   cord_type      ccy   [CORDIC_N+1];
   ang_type       cang  [CORDIC_N+1];
   logic [SD-1:0] cside [CORDIC_N+1];

   assign cv[0]    = fv_ff;
   assign ccx[0]   = fcx_ff;
   assign ccy[0]   = fcy_ff;
   assign cang[0]  = fang_ff;
   assign cside[0] = fside_ff;

   generate
      for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
         cvpi_cordic_cell #(
            .IDX    (k),
            .SIDE_W (SD)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .up_valid (cv[k]),
            .up_cx    (ccx[k]),
            .up_cy    (ccy[k]),
            .up_ang   (cang[k]),
            .up_side  (cside[k]),
            .dn_valid (cv[k+1]),
            .dn_cx    (ccx[k+1]),
            .dn_cy    (ccy[k+1]),
            .dn_ang   (cang[k+1]),
            .dn_side  (cside[k+1])
         );
      end
   endgenerate

   // ---------------- stage E1: phi, phi tolerance, cone distances ----------------
   logic signed [CB-1:0]    e_z;
   logic        [TOL_W-1:0] e_tol;
   logic                    e_zfail, e_sat;
   logic        [CB-1:0]    e_r;
   logic        [DQ_W-1:0]  e_quo;
   ang_type                 ang_rnd;
   ang_type                 ang_sh;
   logic signed [DW-1:0]    din_s, dout_s;

   assign {e_z, e_tol, e_zfail, e_r, e_quo, e_sat} = cside[CORDIC_N];
   assign ang_rnd = cang[CORDIC_N] + (ang_type'(1) <<< (ANG_FRAC - 1 - FB));
   assign ang_sh  = ang_rnd >>> (ANG_FRAC - FB);
   assign din_s   = {e_z[CB-1], e_z} + {inner_level_ff[CB-1], inner_level_ff};
   assign dout_s  = {e_z[CB-1], e_z} + {outer_level_ff[CB-1], outer_level_ff};

   logic                    v4_ff;
   logic                    zfail4_ff, rzero4_ff, tolnz4_ff;
   logic signed [PHI_W-1:0] phi4_ff;
   logic        [PT_W-1:0]  phitol4_ff;
   logic        [DW-1:0]    absdin4_ff, absdout4_ff;
   logic        [DW-1:0]    rmin4_ff;
   logic signed [DW-1:0]    rmax4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= cv[CORDIC_N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zfail4_ff   <= e_zfail;
         rzero4_ff   <= e_r == '0;
         tolnz4_ff   <= e_tol != '0;
         phi4_ff     <= ang_sh[PHI_W-1:0];
         phitol4_ff  <= e_sat ? (PT_W'(16) << FB) : PT_W'(e_quo);
         absdin4_ff  <= din_s[DW-1] ? DW'(-din_s) : DW'(din_s);
         absdout4_ff <= dout_s[DW-1] ? DW'(-dout_s) : DW'(dout_s);
         rmin4_ff    <= DW'(e_r) + DW'(e_tol);
         rmax4_ff    <= signed'(DW'(e_r)) - signed'(DW'(e_tol));
      end
   end

   // ---------------- stage E2: cone products and phi check ----------------
   logic signed [PC_W-1:0] phi_e, pt_e, lo_e, hi_e;
   logic                   phifail5_in;

   assign phi_e = signed'({{(PC_W-PHI_W){phi4_ff[PHI_W-1]}}, phi4_ff});
   assign pt_e  = signed'({{(PC_W-PT_W){1'b0}}, phitol4_ff});
   assign lo_e  = signed'({{(PC_W-PHI_W){phi_low_ff[PHI_W-1]}}, phi_low_ff});
   assign hi_e  = signed'({{(PC_W-PHI_W){phi_high_ff[PHI_W-1]}}, phi_high_ff});
   // on the axis only a zero tolerance passes the sector
   assign phifail5_in = !full_circle_ff &&
                        (rzero4_ff ? tolnz4_ff
                                   : (((phi_e - pt_e) < lo_e) || ((phi_e + pt_e) > hi_e)));

   logic                 v5_ff;
   logic                 zfail5_ff, phifail5_ff;
   logic [PW-1:0]        pin5_ff, pout5_ff;
   logic [DW-1:0]        rmin5_ff;
   logic signed [DW-1:0] rmax5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zfail5_ff   <= zfail4_ff;
         phifail5_ff <= phifail5_in;
         pin5_ff     <= PW'(absdin4_ff) * PW'(inner_tan_ff);
         pout5_ff    <= PW'(absdout4_ff) * PW'(outer_tan_ff);
         rmin5_ff    <= rmin4_ff;
         rmax5_ff    <= rmax4_ff;
      end
   end

   // ---------------- stage E3: radial checks and result register ----------------
   logic [PW-1:0]        rmin_sh, rmax_sh;
   logic signed [DW:0]   in_lvl_e, rmin_e;
   logic signed [DW-1:0] out_lvl_e;
   logic                 infail, outfail;
   logic                 inside_in;
   logic                 inside_ff;

   assign rmin_sh   = PW'(rmin5_ff) << FB;
   assign rmax_sh   = PW'(unsigned'(rmax5_ff)) << FB;
   assign in_lvl_e  = {inner_level_ff[CB-1], inner_level_ff[CB-1], inner_level_ff};
   assign rmin_e    = signed'({1'b0, rmin5_ff});
   assign out_lvl_e = {outer_level_ff[CB-1], outer_level_ff};
   // cone when tan is nonzero, cylinder of radius level otherwise
   assign infail    = (inner_tan_ff != '0) ? (rmin_sh < pin5_ff) : (in_lvl_e > rmin_e);
   assign outfail   = (outer_tan_ff != '0) ? ((rmax5_ff > 0) && (pout5_ff < rmax_sh))
                                           : (out_lvl_e < rmax5_ff);
   assign inside_in = !zfail5_ff && !phifail5_ff && !infail && !outfail;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_inside = inside_ff;
endmodule
